>>> rtl/alignment_gap_run_encoder_defines.svh
// Assertion macros for the alignment gap run encoder checker.
// Needs signal clk, and arst_n for AGRE_ASSERT, in the scope where a macro is used.
`ifndef ALIGNMENT_GAP_RUN_ENCODER_DEFINES_SVH
`define ALIGNMENT_GAP_RUN_ENCODER_DEFINES_SVH

// Checked only while out of reset.
`define AGRE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define AGRE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/agre_pkg.sv
// Shared types, constants and helpers of the alignment gap run encoder.
// No dependencies; every other file of the block but the defines header uses it.
package agre_pkg;

	localparam int POS_BITS = 31;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_COL_START = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_COL_END = 2'd1;

	localparam logic STREAM_ROW = 1'b0;
	localparam logic STREAM_COL = 1'b1;

	// One-hot work steps of the back end, taken in this order.
	localparam int NUM_STEPS = 5;
	localparam logic [NUM_STEPS-1:0] STEP_ROW_GAP = 5'b00001;
	localparam logic [NUM_STEPS-1:0] STEP_COL_GAP = 5'b00010;
	localparam logic [NUM_STEPS-1:0] STEP_RUN = 5'b00100;
	localparam logic [NUM_STEPS-1:0] STEP_FLUSH_COL = 5'b01000;
	localparam logic [NUM_STEPS-1:0] STEP_FLUSH_ROW = 5'b10000;

	typedef logic [POS_BITS-1:0] pos_t;

	typedef struct packed {
		pos_t row_pos;
		pos_t col_pos;
		logic last_pair;
	} pair_t;

	typedef struct packed {
		logic stream_sel;
		pos_t run_len;
		pos_t gap_len;
		logic last_token;
	} token_t;

	typedef struct packed {
		logic init;
		logic run;
		logic row_gap;
		logic col_gap;
		logic flush;
		pos_t d_row;
		pos_t d_col;
	} cmd_t;

	function automatic pos_t sat_add(input pos_t a, input pos_t b);
		logic [POS_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[POS_BITS] ? '1 : sum[POS_BITS-1:0];
	endfunction

endpackage

>>> rtl/agre_front.sv
// Front end: accepts pairs, applies the column window and finds row and column gaps.
// Depends on agre_pkg; feeds commands to agre_fifo.
module agre_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  agre_pkg::pair_t        in_data,
	input  agre_pkg::pos_t         window_start,
	input  agre_pkg::pos_t         window_end,
	output logic                   push,
	output agre_pkg::cmd_t         push_cmd,
	input  logic                   full
);

	localparam int P = agre_pkg::POS_BITS;

	agre_pkg::pos_t prev_row_q;
	agre_pkg::pos_t prev_col_q;
	logic started_q;
	logic stopped_q;

	logic accept;
	logic start_hit;
	logic stop_hit;
	logic normal;
	logic [P:0] row_diff;
	logic [P:0] col_diff;
	logic row_gap;
	logic col_gap;

	assign in_stall = full;
	assign accept = in_valid && !full;

	assign start_hit = !started_q && (in_data.col_pos >= window_start);
	assign stop_hit = started_q && !stopped_q && (in_data.col_pos > window_end);
	assign normal = started_q && !stopped_q && !(in_data.col_pos > window_end);

	// A step of more than one position is a gap; zero or backward steps are not.
	assign row_diff = {1'b0, in_data.row_pos} - {1'b0, prev_row_q} - (P+1)'(1);
	assign col_diff = {1'b0, in_data.col_pos} - {1'b0, prev_col_q} - (P+1)'(1);
	assign row_gap = !row_diff[P] && (row_diff != '0);
	assign col_gap = !col_diff[P] && (col_diff != '0);

	always_comb begin
		push_cmd.init = start_hit;
		push_cmd.run = start_hit || normal;
		push_cmd.row_gap = normal && row_gap;
		push_cmd.col_gap = normal && col_gap;
		push_cmd.flush = in_data.last_pair && (started_q || start_hit);
		push_cmd.d_row = row_diff[P-1:0];
		push_cmd.d_col = col_diff[P-1:0];
	end

	assign push = accept && (push_cmd.run || push_cmd.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_row_q <= '0;
			prev_col_q <= '0;
			started_q <= 1'b0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (in_data.last_pair) begin
				prev_row_q <= '0;
				prev_col_q <= '0;
				started_q <= 1'b0;
				stopped_q <= 1'b0;
			end else begin
				if (start_hit || normal) begin
					prev_row_q <= in_data.row_pos;
					prev_col_q <= in_data.col_pos;
				end
				if (start_hit) begin
					started_q <= 1'b1;
				end
				if (stop_hit) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/agre_fifo.sv
// Short command queue between the front end and the back end.
// Depends on agre_pkg for the command type.
module agre_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  agre_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output agre_pkg::cmd_t head_data
);

	localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	agre_pkg::cmd_t mem_q [DEPTH];
	logic [IDX_BITS-1:0] wr_ptr_q;
	logic [IDX_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_BITS'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + IDX_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + IDX_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule

>>> rtl/agre_back.sv
// Back end: keeps the row and column runs and issues at most one token per cycle, held by out_stall.
// Depends on agre_pkg; takes commands from agre_fifo and drives the output register.
module agre_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  agre_pkg::cmd_t  head_data,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output agre_pkg::token_t out_data
);

	localparam int S = agre_pkg::NUM_STEPS;

	agre_pkg::pos_t row_run_q;
	agre_pkg::pos_t col_run_q;
	logic [S-1:0] done_q;
	logic out_valid_q;
	agre_pkg::token_t out_q;

	logic [S-1:0] need;
	logic [S-1:0] pend;
	logic [S-1:0] sel;
	logic emits;
	logic out_free;
	logic go;
	logic final_step;
	agre_pkg::token_t tok;

	assign need = {head_data.flush, head_data.flush, head_data.run,
		head_data.col_gap, head_data.row_gap};
	assign pend = need & ~done_q;
	assign sel = pend & (~pend + S'(1));
	assign final_step = ((pend & ~sel) == '0);
	assign emits = (sel & (agre_pkg::STEP_ROW_GAP | agre_pkg::STEP_COL_GAP |
		agre_pkg::STEP_FLUSH_COL | agre_pkg::STEP_FLUSH_ROW)) != '0;
	assign out_free = !out_valid_q || !out_stall;
	assign go = head_valid && (!emits || out_free);
	assign pop = go && final_step;

	always_comb begin
		tok.stream_sel = agre_pkg::STREAM_ROW;
		tok.run_len = row_run_q;
		tok.gap_len = '0;
		tok.last_token = 1'b0;
		unique case (sel)
			agre_pkg::STEP_ROW_GAP: begin
				tok.stream_sel = agre_pkg::STREAM_COL;
				tok.run_len = col_run_q;
				tok.gap_len = head_data.d_row;
			end
			agre_pkg::STEP_COL_GAP: begin
				tok.gap_len = head_data.d_col;
			end
			agre_pkg::STEP_FLUSH_COL: begin
				tok.stream_sel = agre_pkg::STREAM_COL;
				tok.run_len = col_run_q;
			end
			agre_pkg::STEP_FLUSH_ROW: begin
				tok.last_token = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_run_q <= '0;
			col_run_q <= '0;
			done_q <= '0;
		end else if (go) begin
			done_q <= final_step ? '0 : (done_q | sel);
			unique case (sel)
				agre_pkg::STEP_ROW_GAP: begin
					col_run_q <= '0;
					row_run_q <= agre_pkg::sat_add(row_run_q, head_data.d_row);
				end
				agre_pkg::STEP_COL_GAP: begin
					row_run_q <= '0;
					col_run_q <= agre_pkg::sat_add(col_run_q, head_data.d_col);
				end
				agre_pkg::STEP_RUN: begin
					if (head_data.init) begin
						row_run_q <= agre_pkg::pos_t'(1);
						col_run_q <= agre_pkg::pos_t'(1);
					end else begin
						row_run_q <= agre_pkg::sat_add(row_run_q, agre_pkg::pos_t'(1));
						col_run_q <= agre_pkg::sat_add(col_run_q, agre_pkg::pos_t'(1));
					end
				end
				agre_pkg::STEP_FLUSH_ROW: begin
					row_run_q <= '0;
					col_run_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= go && emits;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && go && emits) begin
			out_q <= tok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

>>> rtl/alignment_gap_run_encoder.sv
// Top level of the alignment gap run encoder: window registers, front end, queue, back end.
// Depends on agre_pkg, agre_front, agre_fifo and agre_back.
//
//   channel   handshake               payload
//   in        in_valid / in_stall     in_data   (agre_pkg::pair_t)
//   out       out_valid / out_stall   out_data  (agre_pkg::token_t)
//   cfg       cfg_we                  cfg_index, cfg_wdata
//
// Pairs can enter every cycle while the command queue is not full.
// Each token, and the run update of each pair that extends the runs, takes a back-end step;
// a token waiting on out_stall holds the back end, and the
// QUEUE_DEPTH-entry command queue absorbs these bursts.
// Reset clears control state, runs and window_col_start; window_col_end resets to all ones.
// in_stall is high only while the command queue is full.

module alignment_gap_run_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  agre_pkg::pair_t                     in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output agre_pkg::token_t                    out_data,
	input  logic                                cfg_we,
	input  logic [agre_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  agre_pkg::pos_t                      cfg_wdata
);

	agre_pkg::pos_t window_start_q;
	agre_pkg::pos_t window_end_q;

	logic push;
	agre_pkg::cmd_t push_cmd;
	logic full;
	logic pop;
	logic head_valid;
	agre_pkg::cmd_t head_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q <= '0;
			window_end_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				agre_pkg::CFG_WINDOW_COL_START: window_start_q <= cfg_wdata;
				agre_pkg::CFG_WINDOW_COL_END: window_end_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	agre_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.window_start (window_start_q),
		.window_end   (window_end_q),
		.push         (push),
		.push_cmd     (push_cmd),
		.full         (full)
	);

	agre_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	agre_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

>>> rtl/agre_checker.sv
// Port-level checks of the alignment gap run encoder, bound to the top level.
// Depends on agre_pkg and alignment_gap_run_encoder_defines.svh.
`include "alignment_gap_run_encoder_defines.svh"

module agre_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  agre_pkg::token_t                  out_data
);

	// A stalled token holds until its transfer.
	`AGRE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled token changed")

	// The queue fills only through an input transfer.
	`AGRE_ASSERT(a_stall_rise, $rose(in_stall) |-> $past(in_valid && !in_stall), "in_stall rose without a transfer")

	// The closing token is a row-stream token with no gap.
	`AGRE_ASSERT(a_last_tok, out_valid && out_data.last_token |-> out_data.stream_sel == agre_pkg::STREAM_ROW && out_data.gap_len == '0, "bad final token")

	// No token is offered while reset is applied.
	`AGRE_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> out_valid !== 1'b1, "token offered in reset")

endmodule

bind alignment_gap_run_encoder agre_checker u_agre_checker (.*);
